/* rtl/cbs_pkg.sv */
// shared types, constants and helpers of the centered binomial sampler
package cbs_pkg;

    localparam int POLY_DEGREE = 256;
    localparam int IDX_W       = (POLY_DEGREE > 1) ? $clog2(POLY_DEGREE) : 1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [2:0] HW_RESET = 3'd4;
    localparam logic [2:0] HW_ETA3  = 3'd3;
    localparam logic [2:0] HW_ETA5  = 3'd5;

    typedef enum logic [1:0] {
        MODE_W3,
        MODE_W4,
        MODE_W5
    } mode_t;

    // one complete group as handed from front to back
    typedef struct packed {
        logic [39:0] word;
        mode_t       mode;
        logic        restart;
    } group_t;

    function automatic mode_t decode_mode(input logic [2:0] hw);
        mode_t m;
        unique case (hw)
            HW_ETA3: m = MODE_W3;
            HW_ETA5: m = MODE_W5;
            default: m = MODE_W4;
        endcase
        return m;
    endfunction

endpackage

/* rtl/cbs_ifs.sv */
// request channel interfaces of the centered binomial sampler

interface cbs_coin_if;
    logic       valid;
    logic       ready;
    logic [7:0] coin_byte;
    logic       first_byte;

    modport source (output valid, output coin_byte, output first_byte, input ready);
    modport sink   (input valid, input coin_byte, input first_byte, output ready);
endinterface

interface cbs_coeff_if;
    logic              valid;
    logic              ready;
    logic signed [3:0] coefficient;
    logic        [7:0] coeff_index;
    logic              last_of_run;
    logic              last_of_poly;

    modport source (output valid, output coefficient, output coeff_index,
                    output last_of_run, output last_of_poly, input ready);
    modport sink   (input valid, input coefficient, input coeff_index,
                    input last_of_run, input last_of_poly, output ready);
endinterface

interface cbs_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] half_width;

    modport source (output valid, output half_width, input ready);
    modport sink   (input valid, input half_width, output ready);
endinterface

/* rtl/centered_binomial_sampler_core.sv */
// centered binomial sampler: byte front end, group queue, coefficient back end
// a byte that completes a group enters the group queue; its first coefficient
//   then goes to the result channel from the back end's output register
// throughput: one coefficient per cycle while the result channel is ready;
//   eta 4 and eta 5 take a byte every cycle, eta 3 three bytes per 4 coefficients
// reset: clears partial group, coefficient index and queue; half_width returns to 4
module centered_binomial_sampler_core import cbs_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    cbs_coin_if.sink     coins,
    cbs_coeff_if.source  coeffs,
    cbs_cfg_if.sink      cfg
);

    // half width: user writes only while the block is idle; the core does not check
    logic [2:0] half_width_reg, half_width_next;

    // front to queue and queue to back
    logic   push_valid, push_ready;
    group_t push_data;
    logic   pop_valid, pop_ready;
    group_t pop_data;

    // config requests are always taken
    assign cfg.ready = 1'b1;

    always_comb
    begin
        half_width_next = half_width_reg;
        if (cfg.valid)
            half_width_next = cfg.half_width;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            half_width_reg <= HW_RESET;
        else
            half_width_reg <= half_width_next;
    end

    // front: gathers bytes into 3, 1 or 5 byte groups, flags new polynomials
    cbs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .coins      (coins),
        .half_width (half_width_reg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // queue: lets the front keep taking bytes while coefficients drain
    cbs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // back: popcount difference per coefficient, index tracking, output register
    cbs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .coeffs    (coeffs)
    );

endmodule

/* rtl/cbs_front.sv */
// front end: collects coin bytes into groups and pushes complete groups
module cbs_front import cbs_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    cbs_coin_if.sink     coins,
    input  logic [2:0]   half_width,
    output logic         push_valid,
    input  logic         push_ready,
    output group_t       push_data
);

    logic [31:0] pending_reg, pending_next;
    logic [2:0]  held_reg, held_next;
    logic        restart_reg, restart_next;

    logic [31:0] pend;
    logic [2:0]  hb;
    logic        rst_grp;
    logic [3:0]  group_bytes;
    logic        complete;
    logic [39:0] word_raw;
    mode_t       mode;
    logic        accept;

    assign coins.ready = push_ready;
    assign accept      = coins.valid && coins.ready;
    assign mode        = decode_mode(half_width);

    always_comb
    begin
        // a first byte clears the partial group before it is taken in
        pend    = coins.first_byte ? 32'd0 : pending_reg;
        hb      = coins.first_byte ? 3'd0 : held_reg;
        rst_grp = coins.first_byte || restart_reg;

        unique case (mode)
            MODE_W3: group_bytes = 4'd3;
            MODE_W5: group_bytes = 4'd5;
            default: group_bytes = 4'd1;
        endcase

        complete = !(({1'b0, hb} + 4'd1) < group_bytes);
        word_raw = 40'(pend) | (40'(coins.coin_byte) << {hb, 3'b000});

        push_data.mode    = mode;
        push_data.restart = rst_grp;
        unique case (mode)
            MODE_W3: push_data.word = {16'd0, word_raw[23:0]};
            MODE_W5: push_data.word = word_raw;
            default: push_data.word = {32'd0, word_raw[7:0]};
        endcase
        push_valid = coins.valid && complete;

        pending_next = pending_reg;
        held_next    = held_reg;
        restart_next = restart_reg;
        if (accept)
        begin
            if (complete)
            begin
                pending_next = 32'd0;
                held_next    = 3'd0;
                restart_next = 1'b0;
            end
            else
            begin
                pending_next = pend | (32'(coins.coin_byte) << {hb, 3'b000});
                held_next    = hb + 3'd1;
                restart_next = rst_grp;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 32'd0;
            held_reg    <= 3'd0;
            restart_reg <= 1'b0;
        end
        else
        begin
            pending_reg <= pending_next;
            held_reg    <= held_next;
            restart_reg <= restart_next;
        end
    end

endmodule

/* rtl/cbs_queue.sv */
// short group queue between front and back
module cbs_queue import cbs_pkg::*; (
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push_valid,
    output logic   push_ready,
    input  group_t push_data,
    output logic   pop_valid,
    input  logic   pop_ready,
    output group_t pop_data
);

    group_t             mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic               push, pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

/* rtl/cbs_back.sv */
// back end: walks queued groups, one coefficient per cycle while coeffs.ready is high
module cbs_back import cbs_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       pop_valid,
    output logic       pop_ready,
    input  group_t     pop_data,
    cbs_coeff_if.source coeffs
);

    logic [1:0]       k_reg, k_next;
    logic [IDX_W-1:0] idx_reg, idx_next;

    logic             out_valid_reg, out_valid_next;
    logic [3:0]       out_coef_reg, out_coef_next;
    logic [IDX_W-1:0] out_idx_reg, out_idx_next;
    logic             out_last_run_reg, out_last_run_next;
    logic             out_last_poly_reg, out_last_poly_next;

    logic             load;
    logic             last_k;
    logic [IDX_W-1:0] base_idx;
    logic [4:0]       lo_bits, hi_bits;
    logic [2:0]       lo_cnt, hi_cnt;

    function automatic logic [2:0] ones5(input logic [4:0] v);
        logic [2:0] n;
        n = 3'd0;
        for (int i = 0; i < 5; i++)
            n = n + 3'(v[i]);
        return n;
    endfunction

    assign load      = pop_valid && (!out_valid_reg || coeffs.ready);
    assign pop_ready = load && last_k;

    always_comb
    begin
        unique case (pop_data.mode)
            MODE_W3:
            begin
                lo_bits = {2'b00, pop_data.word[6 * k_reg +: 3]};
                hi_bits = {2'b00, pop_data.word[6 * k_reg + 3 +: 3]};
                last_k  = (k_reg == 2'd3);
            end
            MODE_W5:
            begin
                lo_bits = pop_data.word[10 * k_reg +: 5];
                hi_bits = pop_data.word[10 * k_reg + 5 +: 5];
                last_k  = (k_reg == 2'd3);
            end
            default:
            begin
                lo_bits = {1'b0, pop_data.word[3:0]};
                hi_bits = {1'b0, pop_data.word[7:4]};
                last_k  = 1'b1;
            end
        endcase
        lo_cnt = ones5(lo_bits);
        hi_cnt = ones5(hi_bits);

        // new polynomial restarts the index at the group's first coefficient
        base_idx = (k_reg == 2'd0 && pop_data.restart) ? '0 : idx_reg;

        k_next             = k_reg;
        idx_next           = idx_reg;
        out_valid_next     = out_valid_reg;
        out_coef_next      = out_coef_reg;
        out_idx_next       = out_idx_reg;
        out_last_run_next  = out_last_run_reg;
        out_last_poly_next = out_last_poly_reg;

        if (coeffs.ready)
            out_valid_next = 1'b0;
        if (load)
        begin
            out_valid_next     = 1'b1;
            out_coef_next      = {1'b0, lo_cnt} - {1'b0, hi_cnt};
            out_idx_next       = base_idx;
            out_last_run_next  = last_k;
            out_last_poly_next = (base_idx == IDX_W'(POLY_DEGREE - 1));
            idx_next           = (base_idx == IDX_W'(POLY_DEGREE - 1)) ? '0 : base_idx + 1'b1;
            k_next             = last_k ? 2'd0 : k_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg         <= 2'd0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            k_reg         <= k_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_coef_reg      <= out_coef_next;
        out_idx_reg       <= out_idx_next;
        out_last_run_reg  <= out_last_run_next;
        out_last_poly_reg <= out_last_poly_next;
    end

    assign coeffs.valid        = out_valid_reg;
    assign coeffs.coefficient  = out_coef_reg;
    assign coeffs.coeff_index  = 8'(out_idx_reg);
    assign coeffs.last_of_run  = out_last_run_reg;
    assign coeffs.last_of_poly = out_last_poly_reg;

`ifndef SYNTHESIS
    // a group part way through stays at the queue head
    assert property (@(posedge clk) disable iff (!rst_n) (k_reg != 2'd0) |-> pop_valid)
        else $error("group left the queue before its last coefficient");

    // releasing a group always leaves its closing coefficient in the output register
    assert property (@(posedge clk) disable iff (!rst_n)
        (pop_valid && pop_ready) |=> (out_valid_reg && out_last_run_reg))
        else $error("group released without a closing coefficient");

    // last_of_poly marks exactly the top index
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_last_poly_reg == (out_idx_reg == IDX_W'(POLY_DEGREE - 1))))
        else $error("last_of_poly out of step with coefficient index");

    // waiting work is never left idle behind an empty output register
    assert property (@(posedge clk) disable iff (!rst_n)
        (pop_valid && !out_valid_reg) |=> out_valid_reg)
        else $error("back end idle with a group queued");
`endif

endmodule

/* sim/centered_binomial_sampler_core_tb.sv */
// self-checking testbench of the centered binomial sampler core

typedef struct packed {
    logic signed [3:0] coefficient;
    logic        [7:0] coeff_index;
    logic              last_of_run;
    logic              last_of_poly;
} coeff_t;

class coeff_predictor;
    logic [2:0]  half_width;
    logic [31:0] held_bytes;
    logic [2:0]  held_count;
    int          next_index;
    coeff_t      coeffs_due[$];
    int          mismatches;

    function new();
        half_width = cbs_pkg::HW_RESET;
        held_bytes = '0;
        held_count = '0;
        next_index = 0;
        mismatches = 0;
    endfunction

    function void write_width(input logic [2:0] hw);
        half_width = hw;
    endfunction

    // one accepted coin byte, queues the coefficients it completes
    function void take_byte(input logic [7:0] coin, input logic first);
        int              w;
        int              group;
        int              ncoef;
        int              ones_lo;
        int              ones_hi;
        int              base;
        logic [39:0]     word;
        longint unsigned mask;
        coeff_t          c;

        if (first) begin
            held_bytes = '0;
            held_count = '0;
            next_index = 0;
        end
        if (half_width == cbs_pkg::HW_ETA3) begin
            w = 3; group = 3; ncoef = 4;
        end
        else if (half_width == cbs_pkg::HW_ETA5) begin
            w = 5; group = 5; ncoef = 4;
        end
        else begin
            w = 4; group = 1; ncoef = 1;
        end

        if (int'(held_count) + 1 < group) begin
            held_bytes = held_bytes | (32'(coin) << (8 * held_count));
            held_count = held_count + 3'd1;
            return;
        end

        // group complete, only its own bytes count
        word = {8'h00, held_bytes} | (40'(coin) << (8 * held_count));
        mask = (64'd1 << (8 * group)) - 64'd1;
        word = word & mask[39:0];
        held_bytes = '0;
        held_count = '0;

        for (int k = 0; k < ncoef; k++) begin
            ones_lo = 0;
            ones_hi = 0;
            base = 2 * w * k;
            for (int j = 0; j < w; j++) begin
                ones_lo += int'(word[base + j]);
                ones_hi += int'(word[base + w + j]);
            end
            c.coefficient  = 4'(ones_lo - ones_hi);
            c.coeff_index  = 8'(next_index);
            c.last_of_run  = (k == ncoef - 1);
            c.last_of_poly = (next_index == cbs_pkg::POLY_DEGREE - 1);
            next_index = (next_index + 1 >= cbs_pkg::POLY_DEGREE) ? 0 : next_index + 1;
            coeffs_due.push_back(c);
        end
    endfunction

    function void report(input string what, input coeff_t want, input coeff_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("%s: expected coef %0d idx %0d run %0b poly %0b, got coef %0d idx %0d run %0b poly %0b",
                     what, $signed(want.coefficient), want.coeff_index, want.last_of_run,
                     want.last_of_poly, $signed(got.coefficient), got.coeff_index,
                     got.last_of_run, got.last_of_poly);
    endfunction

    // one accepted coefficient against the oldest one due
    function void check_coeff(input coeff_t got);
        coeff_t want;

        if (coeffs_due.size() == 0) begin
            report("unexpected coefficient", '0, got);
            return;
        end
        want = coeffs_due.pop_front();
        if (got.coefficient !== want.coefficient || got.coeff_index !== want.coeff_index ||
            got.last_of_run !== want.last_of_run || got.last_of_poly !== want.last_of_poly)
            report("coefficient mismatch", want, got);
    endfunction
endclass

module centered_binomial_sampler_core_tb;
    import cbs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    logic clk;
    logic rst_n;

    cbs_coin_if  coin_ch();
    cbs_coeff_if coeff_ch();
    cbs_cfg_if   cfg_ch();

    coeff_predictor pred = new();

    // idle limits per side, zero gives back-to-back requests
    int tx_gap_max = 17;
    int rx_gap_max = 17;
    // one long receiver hold-off, armed by the stimulus
    int rx_hold_cycles = 0;

    int phase_widths[8] = '{5, 0, 3, 7, 5, 1, 3, 4};

    centered_binomial_sampler_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .coins  (coin_ch),
        .coeffs (coeff_ch),
        .cfg    (cfg_ch)
    );

    // 2 ns clock
    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // run time limit, far above the slowest legal run
    initial
    begin
        #1000000;
        $display("DONE: errors detected");
        $finish;
    end

    // all tasks start and end on a falling edge
    task automatic send_byte(input logic [7:0] coin, input logic first);
        repeat ($urandom_range(0, tx_gap_max)) @(negedge clk);
        coin_ch.valid      = 1'b1;
        coin_ch.coin_byte  = coin;
        coin_ch.first_byte = first;
        // hold the request until the core takes it
        do @(posedge clk); while (!coin_ch.ready);
        pred.take_byte(coin, first);
        @(negedge clk);
        coin_ch.valid = 1'b0;
    endtask

    // sends n bytes of a word, least significant byte first
    task automatic send_bytes(input logic [39:0] word, input int n, input logic first);
        for (int i = 0; i < n; i++)
            send_byte(word[8 * i +: 8], first && i == 0);
    endtask

    task automatic wait_drained();
        while (pred.coeffs_due.size() != 0) @(negedge clk);
    endtask

    // register write only with no coefficient in flight
    task automatic write_width(input logic [2:0] hw);
        wait_drained();
        // a byte that only fills a group may still be on its way in
        repeat (6) @(negedge clk);
        cfg_ch.valid      = 1'b1;
        cfg_ch.half_width = hw;
        do @(posedge clk); while (!cfg_ch.ready);
        pred.write_width(hw);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    // coefficient receiver: random ready gaps, check on each accepted request
    initial
    begin
        coeff_t got;

        coeff_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_cycles > 0)
            begin
                // long hold-off so the queue fills and the coin side stalls
                coeff_ch.ready = 1'b0;
                repeat (rx_hold_cycles) @(negedge clk);
                rx_hold_cycles = 0;
            end
            if (rx_gap_max > 0)
            begin
                coeff_ch.ready = 1'b0;
                repeat ($urandom_range(0, rx_gap_max)) @(negedge clk);
            end
            coeff_ch.ready = 1'b1;
            do @(posedge clk); while (!coeff_ch.valid);
            got.coefficient  = coeff_ch.coefficient;
            got.coeff_index  = coeff_ch.coeff_index;
            got.last_of_run  = coeff_ch.last_of_run;
            got.last_of_poly = coeff_ch.last_of_poly;
            pred.check_coeff(got);
        end
    end

    // stimulus
    initial
    begin
        int          n;
        logic [7:0]  coin;
        logic        first;

        rst_n              = 1'b0;
        coin_ch.valid      = 1'b0;
        coin_ch.coin_byte  = '0;
        coin_ch.first_byte = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.half_width  = HW_RESET;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // eta 4 out of reset: +4, -4, 0, 0
        send_bytes(40'hFF_00_F0_0F, 4, 1'b1);

        // eta 3: all +3, then all -3
        write_width(HW_ETA3);
        send_bytes(40'h1C71C7, 3, 1'b1);
        send_bytes(40'hE38E38, 3, 1'b0);

        // eta 5: all +5, then all -5
        write_width(HW_ETA5);
        send_bytes(40'h07C1F07C1F, 5, 1'b1);
        send_bytes(40'hF83E0F83E0, 5, 1'b0);

        // new polynomial in the middle of a group drops the held bytes
        send_bytes(40'($urandom), 2, 1'b0);
        send_bytes({8'($urandom), 32'($urandom)}, 5, 1'b1);

        // width drops while bytes are held: next byte completes the group
        send_bytes(40'($urandom), 2, 1'b0);
        write_width(HW_ETA3);
        send_byte(8'($urandom), 1'b0);

        // after switching to eta 4 the held byte forms the group, the new byte is dropped
        send_byte(8'($urandom), 1'b0);
        write_width(HW_RESET);
        send_byte(8'($urandom), 1'b0);

        // a whole eta 3 polynomial and a little past its end, so the index wraps
        write_width(HW_ETA3);
        tx_gap_max = 0;
        rx_gap_max = 0;
        for (int i = 0; i < 196; i++)
        begin
            if (i == 40)
                rx_hold_cycles = 80;
            if (i == 100)
            begin
                // sender waits for every coefficient, then random idling on both sides
                wait_drained();
                tx_gap_max = 17;
                rx_gap_max = 17;
            end
            send_byte(8'($urandom), i == 0);
        end

        // short phases at every kind of width, with stray restarts and
        // groups left open across width changes
        foreach (phase_widths[p])
        begin
            tx_gap_max = (p % 3 == 1) ? 0 : 17;
            rx_gap_max = (p % 3 == 2) ? 0 : 17;
            write_width(3'(phase_widths[p]));
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++)
            begin
                case ($urandom_range(0, 9))
                    0:       coin = 8'h00;
                    1:       coin = 8'hFF;
                    default: coin = 8'($urandom);
                endcase
                first = (p % 2 == 0 && i == 0) || ($urandom_range(0, 15) == 0);
                send_byte(coin, first);
            end
        end

        wait_drained();
        repeat (16) @(negedge clk);
        if (pred.mismatches == 0 && pred.coeffs_due.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
